// ===== design/assert_macros.svh =====
// assertion macros shared by the touch gesture classifier modules
// every user module has ports named clk and rst_n

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define TGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tgc_pkg.sv =====
// types and constants shared by the touch gesture classifier modules
// no dependencies
`timescale 1ns / 1ps

package tgc_pkg;

    typedef enum logic [1:0] {
        GEST_NONE        = 2'd0,
        GEST_SINGLE_DRAG = 2'd1,
        GEST_TWO_DRAG    = 2'd2,
        GEST_PINCH       = 2'd3
    } gesture_t;

    localparam logic [1:0] PH_BEGAN = 2'd0;
    localparam logic [1:0] PH_MOVED = 2'd1;
    localparam logic [1:0] PH_ENDED = 2'd2;
    localparam logic [1:0] PH_OTHER = 2'd3;

    // fractional bits of the spacing result
    localparam int FRAC_BITS = 4;

    // configuration register widths and map
    localparam int WIN_BITS  = 32;
    localparam int THR_BITS  = 17;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam logic [0:0] REG_DETECT_WINDOW   = 1'b0;
    localparam logic [0:0] REG_PINCH_THRESHOLD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_LOAD,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic load;
        logic pair_sel;   // 0 start positions, 1 current positions
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic go;
        logic root_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/tgc_regs.sv =====
// configuration registers on the apb-style port
// depends on tgc_pkg
`timescale 1ns / 1ps

module tgc_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgc_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [tgc_pkg::DATA_BITS-1:0]       pwdata,
    output logic [tgc_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready,
    output logic [tgc_pkg::WIN_BITS-1:0]        detect_window,
    output logic signed [tgc_pkg::THR_BITS-1:0] pinch_threshold
);

    logic [tgc_pkg::WIN_BITS-1:0]        window_reg;
    logic signed [tgc_pkg::THR_BITS-1:0] thresh_reg;
    logic [0:0]                          index;
    logic                                wr_en;

    assign index  = paddr[tgc_pkg::ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            thresh_reg <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                tgc_pkg::REG_DETECT_WINDOW:
                    window_reg <= pwdata[tgc_pkg::WIN_BITS-1:0];
                tgc_pkg::REG_PINCH_THRESHOLD:
                    thresh_reg <= pwdata[tgc_pkg::THR_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            tgc_pkg::REG_DETECT_WINDOW:
                prdata = window_reg;
            tgc_pkg::REG_PINCH_THRESHOLD:
                prdata = {{(tgc_pkg::DATA_BITS-tgc_pkg::THR_BITS){thresh_reg[tgc_pkg::THR_BITS-1]}},
                          thresh_reg};
            default:
                prdata = '0;
        endcase
    end

    assign detect_window   = window_reg;
    assign pinch_threshold = thresh_reg;

endmodule

// ===== design/tgc_ctrl.sv =====
// controller state machine: sequences capture, decision, two spacing passes when needed, and result
// depends on tgc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tgc_pkg::dp_status_t status,
    output tgc_pkg::dp_cmd_t    cmd
);

    tgc_pkg::state_t state_reg, state_next;
    logic            sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgc_pkg::ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            tgc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = tgc_pkg::ST_EVAL;
            tgc_pkg::ST_EVAL:
                state_next = tgc_pkg::ST_DECIDE;
            tgc_pkg::ST_DECIDE:
            begin
                sel_next = 1'b0;
                if (status.go)
                    state_next = tgc_pkg::ST_LOAD;
                else
                    state_next = tgc_pkg::ST_FINISH;
            end
            tgc_pkg::ST_LOAD:
                state_next = tgc_pkg::ST_SQX;
            tgc_pkg::ST_SQX:
                state_next = tgc_pkg::ST_SQY;
            tgc_pkg::ST_SQY:
                state_next = tgc_pkg::ST_ROOT;
            tgc_pkg::ST_ROOT:
                if (status.root_last)
                begin
                    if (sel_reg)
                        state_next = tgc_pkg::ST_FINISH;
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = tgc_pkg::ST_LOAD;
                    end
                end
            tgc_pkg::ST_FINISH:
                if (status.out_free)
                    state_next = tgc_pkg::ST_IDLE;
            default:
                state_next = tgc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.pair_sel = sel_reg;
        in_stall     = 1'b1;
        case (state_reg)
            tgc_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            tgc_pkg::ST_EVAL:
                cmd.eval = 1'b1;
            tgc_pkg::ST_LOAD:
                cmd.load = 1'b1;
            tgc_pkg::ST_SQX:
                cmd.sq_x = 1'b1;
            tgc_pkg::ST_SQY:
                cmd.sq_y = 1'b1;
            tgc_pkg::ST_ROOT:
                cmd.root_step = 1'b1;
            tgc_pkg::ST_FINISH:
                cmd.finish = status.out_free;
            default:
                ;
        endcase
    end

    `TGC_ASSERT_NXT(a_accept_to_eval, in_valid && !in_stall,
        state_reg == tgc_pkg::ST_EVAL, "accepted transaction not followed by eval")
    `TGC_ASSERT_NXT(a_finish_to_idle, cmd.finish,
        state_reg == tgc_pkg::ST_IDLE, "result written but controller not idle next")
    `TGC_ASSERT_IMP(a_finish_only_free, cmd.finish, status.out_free,
        "result written while output slot busy")

endmodule

// ===== design/tgc_dp.sv =====
// datapath: captured frame, start and last records, shared squarer and
// bit-serial square root, gesture decision and output register
// depends on tgc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgc_dp #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tgc_pkg::dp_cmd_t                    cmd,
    output tgc_pkg::dp_status_t                 status,
    input  logic [tgc_pkg::WIN_BITS-1:0]        detect_window,
    input  logic signed [tgc_pkg::THR_BITS-1:0] pinch_threshold,
    input  logic                                prim_present,
    input  logic [1:0]                          prim_phase,
    input  logic [COORD_BITS-1:0]               prim_x,
    input  logic [COORD_BITS-1:0]               prim_y,
    input  logic [TIME_BITS-1:0]                prim_stamp,
    input  logic                                sec_present,
    input  logic [1:0]                          sec_phase,
    input  logic [COORD_BITS-1:0]               sec_x,
    input  logic [COORD_BITS-1:0]               sec_y,
    input  logic [TIME_BITS-1:0]                frame_now,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          gesture,
    output logic                                delta_valid,
    output logic signed [COORD_BITS:0]          delta_x,
    output logic signed [COORD_BITS:0]          delta_y
);

    localparam int SQW  = 2 * COORD_BITS;
    localparam int RW   = COORD_BITS + 1 + tgc_pkg::FRAC_BITS;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 3;
    localparam int CNTW = $clog2(RW + 1);
    localparam int EW   = (TIME_BITS > tgc_pkg::WIN_BITS) ? TIME_BITS : tgc_pkg::WIN_BITS;
    localparam int CMPW = (RW + 1 > tgc_pkg::THR_BITS) ? RW + 1 : tgc_pkg::THR_BITS;

    // captured frame
    logic                  pp_reg, sp_reg;
    logic [1:0]            pph_reg, sph_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, sx_reg, sy_reg;
    logic [TIME_BITS-1:0]  stamp_reg, now_reg;

    // gesture state
    tgc_pkg::gesture_t     gest_reg, gest_next;
    logic                  spv_reg, ssv_reg, lpv_reg;
    logic [COORD_BITS-1:0] spx_reg, spy_reg, ssx_reg, ssy_reg, lpx_reg, lpy_reg;
    logic [TIME_BITS-1:0]  spt_reg;
    logic                  go_reg;

    // spacing arithmetic
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [SQW-1:0]        acc_reg;
    logic [RADW-1:0]       rad_reg;
    logic [REMW-1:0]       rem_reg;
    logic [RW-1:0]         root_reg, d0_reg;
    logic [CNTW-1:0]       cnt_reg;

    // output slot
    logic                  out_valid_reg, dv_reg;
    tgc_pkg::gesture_t     out_gest_reg;
    logic [COORD_BITS:0]   dlx_reg, dly_reg;

    logic                  began_p, began_s, prim_live, sec_live;
    logic [TIME_BITS-1:0]  t0, elapsed;
    logic                  go;
    logic [COORD_BITS-1:0] ax, ay, bx, by, adx, ady;
    logic [SQW-1:0]        sq_op;
    logic [SQW-1:0]        sq_prod;
    logic [SQW:0]          sq_sum;
    logic [REMW-1:0]       rem_sh, trial;
    logic                  ge;
    logic signed [RW:0]    growth;
    logic                  below;
    logic                  dv;
    logic [COORD_BITS:0]   dlx, dly;

    assign began_p   = pp_reg && (pph_reg == tgc_pkg::PH_BEGAN);
    assign began_s   = sp_reg && (sph_reg == tgc_pkg::PH_BEGAN);
    assign prim_live = pp_reg && (pph_reg != tgc_pkg::PH_ENDED);
    assign sec_live  = sp_reg && (sph_reg != tgc_pkg::PH_ENDED);

    // decision inputs see the start records as updated by this frame
    assign t0      = began_p ? stamp_reg : spt_reg;
    assign elapsed = now_reg - t0;
    assign go      = prim_live && (gest_reg == tgc_pkg::GEST_SINGLE_DRAG) && sec_live
                     && (EW'(elapsed) < EW'(detect_window))
                     && (spv_reg || began_p) && (ssv_reg || began_s);

    // pair select for the spacing passes
    always_comb
    begin
        if (cmd.pair_sel)
        begin
            ax = px_reg;  ay = py_reg;  bx = sx_reg;  by = sy_reg;
        end
        else
        begin
            ax = spx_reg; ay = spy_reg; bx = ssx_reg; by = ssy_reg;
        end
    end

    assign adx = (ax >= bx) ? ax - bx : bx - ax;
    assign ady = (ay >= by) ? ay - by : by - ay;

    // one shared squarer
    assign sq_op   = SQW'(cmd.sq_x ? dx_reg : dy_reg);
    assign sq_prod = sq_op * sq_op;
    assign sq_sum  = {1'b0, acc_reg} + {1'b0, sq_prod};

    // one root bit per step
    assign rem_sh = {rem_reg[REMW-3:0], rad_reg[RADW-1 -: 2]};
    assign trial  = REMW'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    assign growth = $signed({1'b0, root_reg}) - $signed({1'b0, d0_reg});
    assign below  = $signed(CMPW'(growth)) < $signed(CMPW'(pinch_threshold));

    always_comb
    begin
        gest_next = gest_reg;
        if (!prim_live)
            gest_next = tgc_pkg::GEST_NONE;
        else if (began_p && (gest_reg == tgc_pkg::GEST_NONE))
            gest_next = tgc_pkg::GEST_SINGLE_DRAG;
        else if (go_reg)
            gest_next = below ? tgc_pkg::GEST_TWO_DRAG : tgc_pkg::GEST_PINCH;
    end

    assign dv  = (gest_next != tgc_pkg::GEST_NONE) && prim_live && lpv_reg;
    assign dlx = {1'b0, px_reg} - {1'b0, lpx_reg};
    assign dly = {1'b0, py_reg} - {1'b0, lpy_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gest_reg      <= tgc_pkg::GEST_NONE;
            spv_reg       <= 1'b0;
            ssv_reg       <= 1'b0;
            lpv_reg       <= 1'b0;
            go_reg        <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                go_reg <= go;
                if (began_p)
                    spv_reg <= 1'b1;
                if (began_s)
                    ssv_reg <= 1'b1;
            end
            if (cmd.sq_y)
                cnt_reg <= CNTW'(RW);
            else if (cmd.root_step)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.finish)
            begin
                gest_reg <= gest_next;
                lpv_reg  <= prim_live;
                if (!prim_live)
                    spv_reg <= 1'b0;
                if (!sec_live)
                    ssv_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pp_reg    <= prim_present;
            pph_reg   <= prim_phase;
            px_reg    <= prim_x;
            py_reg    <= prim_y;
            stamp_reg <= prim_stamp;
            sp_reg    <= sec_present;
            sph_reg   <= sec_phase;
            sx_reg    <= sec_x;
            sy_reg    <= sec_y;
            now_reg   <= frame_now;
        end
        if (cmd.eval && began_p)
        begin
            spx_reg <= px_reg;
            spy_reg <= py_reg;
            spt_reg <= stamp_reg;
        end
        if (cmd.eval && began_s)
        begin
            ssx_reg <= sx_reg;
            ssy_reg <= sy_reg;
        end
        if (cmd.load)
        begin
            dx_reg <= adx;
            dy_reg <= ady;
            // second pass keeps the start spacing
            if (cmd.pair_sel)
                d0_reg <= root_reg;
        end
        if (cmd.sq_x)
            acc_reg <= sq_prod;
        if (cmd.sq_y)
        begin
            rad_reg  <= RADW'({sq_sum, {(2 * tgc_pkg::FRAC_BITS){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RW-2:0], ge};
        end
        if (cmd.finish)
        begin
            if (prim_live)
            begin
                lpx_reg <= px_reg;
                lpy_reg <= py_reg;
            end
            out_gest_reg <= gest_next;
            dv_reg       <= dv;
            dlx_reg      <= dv ? dlx : '0;
            dly_reg      <= dv ? dly : '0;
        end
    end

    assign status.go        = go_reg;
    assign status.root_last = (cnt_reg == CNTW'(1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign gesture     = out_gest_reg;
    assign delta_valid = dv_reg;
    assign delta_x     = $signed(dlx_reg);
    assign delta_y     = $signed(dly_reg);

    `TGC_ASSERT_IMP(a_delta_zero, out_valid_reg && !dv_reg,
        dlx_reg == '0 && dly_reg == '0, "delta nonzero while not valid")
    `TGC_ASSERT_IMP(a_delta_needs_gesture, out_valid_reg && dv_reg,
        out_gest_reg != tgc_pkg::GEST_NONE, "delta valid with no gesture")
    `TGC_ASSERT_IMP(a_root_count, cmd.root_step, cnt_reg != '0,
        "root step issued with no bits left")

endmodule

// ===== design/touch_gesture_classifier.sv =====
// touch gesture classifier: sorts each touch frame summary into none,
// one-finger drag, two-finger drag or pinch and reports the primary's motion.
// A frame transaction is taken on the input channel when in_valid is high and
// in_stall is low; its single result transaction leaves on the output channel
// when out_valid is high and out_stall is low. The user must write detect_window and
// pinch_threshold over the apb-style port only while the block is idle (not enforced).
// A frame that needs no spacing check goes from acceptance through the eval, decide
// and finish states, and the next frame may enter once the controller is idle again.
// A frame in single-finger drag with a live second touch inside the detect window
// runs two spacing passes on one shared squarer and a one-bit-per-cycle square root
// of COORD_BITS+5 steps, each pass going through the load, square and root states.
// One frame is in work at a time; the output register holds a finished result
// while the next frame is accepted and processed.
// A stalled receiver holds the result steady; the following result waits in its
// final cycle until the output register frees, and in_stall stays high meanwhile.
// Reset clears the gesture to none, invalidates all start and last-position records
// and clears both configuration registers to zero.
// depends on tgc_pkg, tgc_regs, tgc_ctrl, tgc_dp
`timescale 1ns / 1ps

module touch_gesture_classifier #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tgc_pkg::DATA_BITS-1:0] pwdata,
    output logic [tgc_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          prim_present,
    input  logic [1:0]                    prim_phase,
    input  logic [COORD_BITS-1:0]         prim_x,
    input  logic [COORD_BITS-1:0]         prim_y,
    input  logic [TIME_BITS-1:0]          prim_stamp,
    input  logic                          sec_present,
    input  logic [1:0]                    sec_phase,
    input  logic [COORD_BITS-1:0]         sec_x,
    input  logic [COORD_BITS-1:0]         sec_y,
    input  logic [TIME_BITS-1:0]          frame_now,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    gesture,
    output logic                          delta_valid,
    output logic signed [COORD_BITS:0]    delta_x,
    output logic signed [COORD_BITS:0]    delta_y
);

    logic [tgc_pkg::WIN_BITS-1:0]        detect_window;
    logic signed [tgc_pkg::THR_BITS-1:0] pinch_threshold;
    tgc_pkg::dp_cmd_t                    cmd;
    tgc_pkg::dp_status_t                 status;

    tgc_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .detect_window   (detect_window),
        .pinch_threshold (pinch_threshold)
    );

    tgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tgc_dp #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .detect_window   (detect_window),
        .pinch_threshold (pinch_threshold),
        .prim_present    (prim_present),
        .prim_phase      (prim_phase),
        .prim_x          (prim_x),
        .prim_y          (prim_y),
        .prim_stamp      (prim_stamp),
        .sec_present     (sec_present),
        .sec_phase       (sec_phase),
        .sec_x           (sec_x),
        .sec_y           (sec_y),
        .frame_now       (frame_now),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .gesture         (gesture),
        .delta_valid     (delta_valid),
        .delta_x         (delta_x),
        .delta_y         (delta_y)
    );

endmodule
